[sv/utf8cn_pkg.sv]
package utf8cn_pkg;

    // Code point limits
    localparam logic [20:0] MAX_CP      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] ONE_BYTE_HI = 21'h00007F;
    localparam logic [20:0] TWO_BYTE_HI = 21'h0007FF;
    localparam logic [20:0] THR_BYTE_HI = 21'h00FFFF;

    // Fallback register reset value: '?'
    localparam logic [20:0] FALLBACK_RESET = 21'd63;

    // Most output bytes one input byte may cause
    localparam logic [6:0] MAX_RUN_BYTES = 7'd13;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Work for the back end, one per input byte that produces output
    typedef struct packed {
        logic [2:0]  nfb;        // fallback characters before the main one
        logic        main_valid; // a main character follows the fallbacks
        logic [20:0] main_cp;    // main character code point
        logic        eot;        // input byte closed the text
    } cmd_t;

    // Number of bytes in the UTF-8 encoding
    function automatic logic [2:0] enc_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= ONE_BYTE_HI)
            len = 3'd1;
        else if (cp <= TWO_BYTE_HI)
            len = 3'd2;
        else if (cp <= THR_BYTE_HI)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    // Byte idx of the UTF-8 encoding
    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (enc_len(cp))
            3'd1: b = cp[7:0];
            3'd2:
            begin
                if (idx == 2'd0)
                    b = {3'b110, cp[10:6]};
                else
                    b = {2'b10, cp[5:0]};
            end
            3'd3:
            begin
                case (idx)
                    2'd0:    b = {4'b1110, cp[15:12]};
                    2'd1:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = {5'b11110, cp[20:18]};
                    2'd1:    b = {2'b10, cp[17:12]};
                    2'd2:    b = {2'b10, cp[11:6]};
                    default: b = {2'b10, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[sv/utf8cn_front.sv]
module utf8cn_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    input  logic                    end_of_text,
    input  logic [20:0]             fallback,
    input  logic                    q_full,
    output logic                    q_push,
    output utf8cn_pkg::cmd_t        q_cmd
);
    import utf8cn_pkg::*;

    // Sequence collection state
    logic [7:0] pend_reg [3];
    logic [1:0] pcnt_reg, pcnt_next;
    logic [2:0] exp_reg, exp_next;

    logic        accept;
    logic        is_cont;
    logic [2:0]  lead_len;
    logic [20:0] dec_cp;
    logic        dec_ok;
    logic        fresh_main;
    logic [20:0] fresh_cp;
    logic        fresh_store;
    logic        store;
    logic [1:0]  store_idx;
    logic [2:0]  nfb;
    logic        main_valid;
    logic [20:0] main_cp;
    logic [6:0]  run_len;

    assign accept   = in_valid && in_ready;
    assign in_ready = !q_full;
    assign is_cont  = (in_byte[7:6] == 2'b10);

    // Lead byte classification
    always_comb
    begin
        case (in_byte) inside
            [8'hC0:8'hDF]: lead_len = 3'd2;
            [8'hE0:8'hEF]: lead_len = 3'd3;
            [8'hF0:8'hF7]: lead_len = 3'd4;
            default:       lead_len = 3'd0;
        endcase
    end

    // Decode pending bytes plus this continuation
    always_comb
    begin
        case (pcnt_reg)
            2'd1:    dec_cp = {10'd0, pend_reg[0][4:0], in_byte[5:0]};
            2'd2:    dec_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte[5:0]};
            default: dec_cp = {pend_reg[0][2:0], pend_reg[1][5:0],
                               pend_reg[2][5:0], in_byte[5:0]};
        endcase
        dec_ok = !(dec_cp > MAX_CP) && !(dec_cp >= SURR_LO && dec_cp <= SURR_HI);
    end

    // Byte taken with nothing pending
    always_comb
    begin
        fresh_main  = 1'b0;
        fresh_store = 1'b0;
        fresh_cp    = fallback;
        if (!in_byte[7])
        begin
            fresh_main = 1'b1;
            fresh_cp   = {13'd0, in_byte};
        end
        else if (lead_len != 3'd0 && !end_of_text)
            fresh_store = 1'b1;
        else
            fresh_main = 1'b1;
    end

    // Classify the byte into a command and next state
    always_comb
    begin
        nfb        = 3'd0;
        main_valid = 1'b0;
        main_cp    = fresh_cp;
        store      = 1'b0;
        store_idx  = 2'd0;
        pcnt_next  = pcnt_reg;
        exp_next   = exp_reg;

        if (pcnt_reg != 2'd0 && is_cont)
        begin
            if ({1'b0, pcnt_reg} + 3'd1 >= exp_reg)
            begin
                main_valid = 1'b1;
                main_cp    = dec_ok ? dec_cp : fallback;
                pcnt_next  = 2'd0;
            end
            else if (end_of_text)
            begin
                nfb       = {1'b0, pcnt_reg} + 3'd1;
                pcnt_next = 2'd0;
            end
            else
            begin
                store     = 1'b1;
                store_idx = pcnt_reg;
                pcnt_next = pcnt_reg + 2'd1;
            end
        end
        else
        begin
            // broken sequence: one fallback per pending byte, then fresh
            nfb        = {1'b0, pcnt_reg};
            main_valid = fresh_main;
            pcnt_next  = 2'd0;
            if (fresh_store)
            begin
                store     = 1'b1;
                pcnt_next = 2'd1;
                exp_next  = lead_len;
            end
        end

        if (end_of_text)
            pcnt_next = 2'd0;
        if (pcnt_next == 2'd0)
            exp_next = 3'd0;

        // drop a main character that would overrun the run limit
        run_len = 7'({3'd0, nfb} * {3'd0, enc_len(fallback)}) + {4'd0, enc_len(main_cp)};
        if (main_valid && run_len > MAX_RUN_BYTES)
            main_valid = 1'b0;
    end

    assign q_push             = accept && (nfb != 3'd0 || main_valid);
    assign q_cmd.nfb          = nfb;
    assign q_cmd.main_valid   = main_valid;
    assign q_cmd.main_cp      = main_cp;
    assign q_cmd.eot          = end_of_text;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= 2'd0;
            exp_reg  <= 3'd0;
        end
        else if (accept)
        begin
            pcnt_reg <= pcnt_next;
            exp_reg  <= exp_next;
        end
    end

    // Pending bytes, no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (accept && store && store_idx == 2'(i))
                pend_reg[i] <= in_byte;
        end
    end

    // An open sequence always expects more than it holds
    a_exp_above_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pcnt_reg != 2'd0) |-> (exp_reg > {1'b0, pcnt_reg}))
        else $error("expected length not above pending count");

    a_exp_clear_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pcnt_reg == 2'd0) |-> (exp_reg == 3'd0))
        else $error("expected length left set with nothing pending");

endmodule

[sv/utf8cn_queue.sv]
module utf8cn_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  utf8cn_pkg::cmd_t    push_cmd,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output utf8cn_pkg::cmd_t    head_cmd
);
    import utf8cn_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entries, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop)
        else $error("command queue overflow");

endmodule

[sv/utf8cn_back.sv]
module utf8cn_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [20:0]         fallback,
    input  logic                head_valid,
    input  utf8cn_pkg::cmd_t    head_cmd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                last_of_run,
    output logic                text_done
);
    import utf8cn_pkg::*;

    // Position inside the current run
    logic [2:0]  char_idx_reg, char_idx_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;
    logic        done_reg;

    logic        in_fb;
    logic [20:0] cur_cp;
    logic [2:0]  cur_len;
    logic        char_end;
    logic        last_char;
    logic        run_end;
    logic        fire;

    // Current character and byte
    assign in_fb     = (char_idx_reg < head_cmd.nfb);
    assign cur_cp    = in_fb ? fallback : head_cmd.main_cp;
    assign cur_len   = enc_len(cur_cp);
    assign char_end  = ({1'b0, byte_idx_reg} + 3'd1 == cur_len);
    assign last_char = in_fb ? ((char_idx_reg + 3'd1 == head_cmd.nfb) && !head_cmd.main_valid)
                             : 1'b1;
    assign run_end   = char_end && last_char;
    assign fire      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = fire && run_end;

    // Step through the run
    always_comb
    begin
        char_idx_next = char_idx_reg;
        byte_idx_next = byte_idx_reg;
        if (fire)
        begin
            if (run_end)
            begin
                char_idx_next = 3'd0;
                byte_idx_next = 2'd0;
            end
            else if (char_end)
            begin
                char_idx_next = char_idx_reg + 3'd1;
                byte_idx_next = 2'd0;
            end
            else
                byte_idx_next = byte_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_idx_reg  <= 3'd0;
            byte_idx_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            char_idx_reg <= char_idx_next;
            byte_idx_reg <= byte_idx_next;
            if (!out_valid_reg || out_ready)
                out_valid_reg <= head_valid;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg <= enc_byte(cur_cp, byte_idx_reg);
            last_reg     <= run_end;
            done_reg     <= run_end && head_cmd.eot;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign text_done   = done_reg;

    a_char_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (char_idx_reg <= head_cmd.nfb))
        else $error("character index past the run");

    a_byte_in_char: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ({1'b0, byte_idx_reg} < cur_len))
        else $error("byte index past the character");

endmodule

[sv/utf8_canonical_normalizer.sv]
// Channel | Handshake            | Payload
// --------+----------------------+----------------------------------------
// in      | in_valid / in_ready  | in_byte[7:0], end_of_text
// out     | out_valid / out_ready| out_byte[7:0], last_of_run, text_done
// cfg     | cfg_valid / cfg_ready| cfg_data[20:0] (fallback code point)
//
// One input byte per cycle is taken while the 4-entry command queue has room.
// The back end emits one output byte per cycle while out_ready allows; a byte
// causing k output bytes holds it until all k are sent via the output register.
// Bytes that only extend a sequence cost no back-end cycle.
// Reset clears the open sequence, the queue and sets the fallback to '?'.
// A stalled output holds the output register; the queue absorbs the front.
module utf8_canonical_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_of_run,
    output logic        text_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [20:0] cfg_data
);
    import utf8cn_pkg::*;

    logic [20:0] fallback_reg;
    logic        q_full;
    logic        q_push;
    cmd_t        q_cmd;
    logic        q_pop;
    logic        head_valid;
    cmd_t        head_cmd;

    // Fallback register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fallback_reg <= FALLBACK_RESET;
        else if (cfg_valid && cfg_ready)
            fallback_reg <= cfg_data;
    end

    utf8cn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .fallback    (fallback_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    utf8cn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    utf8cn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fallback    (fallback_reg),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .text_done   (text_done)
    );

endmodule
